// ===== design/bed_pkg.sv =====
// Shared types, constants and helpers for the backslash escape decoder.
package bed_pkg;

	localparam int MAX_LENGTH = 1024;
	localparam int LEN_W = 11;
	localparam int LEN_CAP = (MAX_LENGTH < 2047) ? MAX_LENGTH : 2047;
	localparam logic [LEN_W-1:0] CNT_CAP = LEN_W'(LEN_CAP);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] ESC_CODE = 8'd27;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_BSLASH,
		MODE_OCTAL,
		MODE_HEX,
		MODE_DISCARD
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_DONE,
		KIND_FAIL
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_OCTAL_DIGIT,
		ERR_OCTAL_RANGE,
		ERR_HEX_DIGIT,
		ERR_BARE_BSLASH
	} err_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       out_byte;
		err_t             error_code;
		logic [LEN_W-1:0] length_count;
		logic             last;
	} result_t;

	// {valid, value} for one hex digit character
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
				d = c - CH_LOWER_A + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
				d = c - CH_UPPER_A + 8'd10;
				hex_digit = {1'b1, d[3:0]};
			end else begin
				hex_digit = {1'b0, d[3:0]};
			end
		end
	endfunction

endpackage

// ===== design/bed_in_stage.sv =====
// Input register stage: holds one accepted item until the decode step takes it.
module bed_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  bed_pkg::item_t item_in,
	input  logic          take,
	output logic          s1_valid,
	output bed_pkg::item_t s1_item
);
	import bed_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  load;

	assign item_stall = valid_s1 && !take;
	assign load = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item = item_s1;
endmodule

// ===== design/bed_step.sv =====
// Escape decode step: mode, digit and count state plus the per-character next-state logic.
module bed_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s1_valid,
	input  bed_pkg::item_t  s1_item,
	input  logic            out_free,
	output logic            take,
	output logic            res_valid,
	output bed_pkg::result_t res
);
	import bed_pkg::*;

	mode_t            mode_q, mode_n;
	logic [1:0]       dcount_q, dcount_n;
	logic [8:0]       acc_q, acc_n;
	logic [LEN_W-1:0] bcount_q, bcount_n;

	logic             has_res;
	result_t          res_c;
	logic [LEN_W-1:0] cnt_inc;
	logic [8:0]       oct_acc;
	logic [7:0]       hex_acc;
	logic [1:0]       dc_inc;
	logic [4:0]       hx;
	logic [7:0]       c;
	logic             is_oct;

	assign c = s1_item.char_code;
	assign cnt_inc = (bcount_q < CNT_CAP) ? bcount_q + LEN_W'(1) : bcount_q;
	assign oct_acc = {acc_q[5:0], c[2:0]};
	assign hx = hex_digit(c);
	assign hex_acc = {acc_q[3:0], hx[3:0]};
	assign dc_inc = dcount_q + 2'd1;
	assign is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);

	always_comb begin
		mode_n = mode_q;
		dcount_n = dcount_q;
		acc_n = acc_q;
		bcount_n = bcount_q;
		has_res = 1'b0;
		res_c.kind = KIND_DATA;
		res_c.out_byte = 8'd0;
		res_c.error_code = ERR_NONE;
		res_c.length_count = bcount_q;
		res_c.last = 1'b0;

		if (s1_item.end_of_string) begin
			unique case (mode_q)
				MODE_NORMAL: begin
					has_res = 1'b1;
					res_c.kind = KIND_DONE;
					res_c.last = 1'b1;
					bcount_n = '0;
				end
				MODE_BSLASH, MODE_OCTAL, MODE_HEX: begin
					has_res = 1'b1;
					res_c.kind = KIND_FAIL;
					res_c.last = 1'b1;
					if (mode_q == MODE_BSLASH) res_c.error_code = ERR_BARE_BSLASH;
					else if (mode_q == MODE_OCTAL) res_c.error_code = ERR_OCTAL_DIGIT;
					else res_c.error_code = ERR_HEX_DIGIT;
					bcount_n = '0;
					dcount_n = 2'd0;
					acc_n = 9'd0;
					mode_n = MODE_NORMAL;
				end
				default: begin
					mode_n = MODE_NORMAL;
					bcount_n = '0;
					dcount_n = 2'd0;
					acc_n = 9'd0;
				end
			endcase
		end else begin
			unique case (mode_q)
				MODE_NORMAL: begin
					if (c == CH_BSLASH) begin
						mode_n = MODE_BSLASH;
					end else begin
						has_res = 1'b1;
						res_c.out_byte = c;
					end
				end
				MODE_BSLASH: begin
					if (is_oct) begin
						acc_n = {6'd0, c[2:0]};
						dcount_n = 2'd1;
						mode_n = MODE_OCTAL;
					end else if (c == CH_LOWER_X) begin
						acc_n = 9'd0;
						dcount_n = 2'd0;
						mode_n = MODE_HEX;
					end else begin
						has_res = 1'b1;
						res_c.out_byte = (c == CH_UPPER_E || c == CH_LOWER_E) ? ESC_CODE : c;
					end
				end
				MODE_OCTAL: begin
					if (!is_oct) begin
						has_res = 1'b1;
						res_c.kind = KIND_FAIL;
						res_c.error_code = ERR_OCTAL_DIGIT;
						res_c.last = 1'b1;
					end else if (dc_inc != 2'd3) begin
						acc_n = oct_acc;
						dcount_n = dc_inc;
					end else if (oct_acc[8]) begin
						// third digit pushed the value past 0377
						has_res = 1'b1;
						res_c.kind = KIND_FAIL;
						res_c.error_code = ERR_OCTAL_RANGE;
						res_c.last = 1'b1;
					end else begin
						acc_n = oct_acc;
						dcount_n = 2'd0;
						has_res = 1'b1;
						res_c.out_byte = oct_acc[7:0];
					end
				end
				MODE_HEX: begin
					if (!hx[4]) begin
						has_res = 1'b1;
						res_c.kind = KIND_FAIL;
						res_c.error_code = ERR_HEX_DIGIT;
						res_c.last = 1'b1;
					end else if (dc_inc != 2'd2) begin
						acc_n = {1'b0, hex_acc};
						dcount_n = dc_inc;
					end else begin
						acc_n = {1'b0, hex_acc};
						dcount_n = 2'd0;
						has_res = 1'b1;
						res_c.out_byte = hex_acc;
					end
				end
				default: begin
				end
			endcase

			if (has_res) begin
				if (res_c.kind == KIND_DATA) begin
					bcount_n = cnt_inc;
					res_c.length_count = cnt_inc;
					mode_n = MODE_NORMAL;
				end else begin
					bcount_n = '0;
					dcount_n = 2'd0;
					acc_n = 9'd0;
					mode_n = MODE_DISCARD;
				end
			end
		end
	end

	assign take = s1_valid && (!has_res || out_free);
	assign res_valid = take && has_res;
	assign res = res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			dcount_q <= 2'd0;
			acc_q <= 9'd0;
			bcount_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			dcount_q <= dcount_n;
			acc_q <= acc_n;
			bcount_q <= bcount_n;
		end
	end
endmodule

// ===== design/bed_out_stage.sv =====
// Result register: holds one result until the downstream side takes it.
module bed_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  bed_pkg::result_t res,
	output logic             out_free,
	output logic             result_valid,
	input  logic             result_stall,
	output bed_pkg::result_t result
);
	import bed_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign out_free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign result = res_q;
endmodule

// ===== design/backslash_escape_decoder.sv =====
// Top level of the backslash escape decoder.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------------------
//   item     | item_valid / item_stall      | char_code, end_of_string
//   result   | result_valid / result_stall  | kind, out_byte, error_code, length_count, last
//
// One item per cycle sustained while result_stall is low; a result reaches the ports from its item
// through the input register, then decode into the result register.
// The decode state updates once per item, so items with no result take a decode step as well.
// Reset clears the mode, digit count, accumulator and byte count; no clearing pass.
// A stalled result holds the result register; the decode stage waits only when its item
// would produce a result, and item_stall rises once the input register is also full.
module backslash_escape_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [7:0]                    char_code,
	input  logic                          end_of_string,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    out_byte,
	output logic [2:0]                    error_code,
	output logic [bed_pkg::LEN_W-1:0]     length_count,
	output logic                          last
);
	import bed_pkg::*;

	item_t   item_in;
	item_t   s1_item;
	logic    s1_valid;
	logic    take;
	logic    out_free;
	logic    res_valid;
	result_t res;
	result_t result;

	assign item_in.char_code = char_code;
	assign item_in.end_of_string = end_of_string;

	bed_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.take       (take),
		.s1_valid   (s1_valid),
		.s1_item    (s1_item)
	);

	bed_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_item   (s1_item),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	bed_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign kind = result.kind;
	assign out_byte = result.out_byte;
	assign error_code = result.error_code;
	assign length_count = result.length_count;
	assign last = result.last;
endmodule

// ===== design/bed_checker.sv =====
// Port-level checks for the backslash escape decoder, bound to the top level.
module bed_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic [1:0]                kind,
	input logic [7:0]                out_byte,
	input logic [2:0]                error_code,
	input logic [bed_pkg::LEN_W-1:0] length_count,
	input logic                      last
);
	import bed_pkg::*;

	// data items carry no error and never end a string
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_DATA |-> error_code == ERR_NONE && !last
			&& length_count != '0)
		else $error("data item with bad side fields");

	// done and fail results carry no byte and close the string
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_DONE || kind == KIND_FAIL) |-> last && out_byte == 8'd0
			&& ((kind == KIND_DONE && error_code == ERR_NONE)
			|| (kind == KIND_FAIL && error_code != ERR_NONE && error_code <= ERR_BARE_BSLASH)))
		else $error("finish or error item with bad fields");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> kind == KIND_DATA || kind == KIND_DONE || kind == KIND_FAIL)
		else $error("unknown result kind");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> length_count <= CNT_CAP)
		else $error("length count above its cap");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind) && $stable(out_byte)
			&& $stable(length_count))
		else $error("stalled result changed");
endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.out_byte     (out_byte),
	.error_code   (error_code),
	.length_count (length_count),
	.last         (last)
);
